[rtl/fbfl_pkg.sv]
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and constants of the fixed block free list allocator: pool
// geometry, command and status codes, and the structs between its modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fbfl_pkg;

  // entry store geometry
  localparam int STORE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int LINK_W      = IDX_W + 1;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(STORE_DEPTH);

  // chunk geometry
  localparam int BLOCK_SIZE    = 64;
  localparam int MAX_CHUNKS    = 16;
  localparam int FIT_CHUNKS    = STORE_DEPTH / BLOCK_SIZE;
  localparam int USABLE_CHUNKS = (MAX_CHUNKS < FIT_CHUNKS) ? MAX_CHUNKS : FIT_CHUNKS;
  localparam int CHUNK_W       = $clog2(USABLE_CHUNKS + 1);
  localparam logic [LINK_W-1:0]  BLOCK_SIZE_L    = LINK_W'(BLOCK_SIZE);
  localparam logic [CHUNK_W-1:0] USABLE_CHUNKS_L = CHUNK_W'(USABLE_CHUNKS);

  // stream widths
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_RESET = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED  = 3'd0,
    ST_FREED      = 3'd1,
    ST_NULL_IGN   = 3'd2,
    ST_WRONG_SIZE = 3'd3,
    ST_EXHAUSTED  = 3'd4,
    ST_POOL_RESET = 3'd5
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_e;

  // one accepted request
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] entry_index;
    logic             entry_is_null;
    logic             size_matches;
  } item_t;

  // pool bookkeeping
  typedef struct packed {
    logic [LINK_W-1:0]  list_head;
    logic [CHUNK_W-1:0] chunks_open;
    logic [LINK_W-1:0]  fresh_mark;
  } pool_t;

  // outcome of one request
  typedef struct packed {
    pool_t             pool_next;
    logic              emit;
    logic [IDX_W-1:0]  granted;
    status_e           status;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_data;
  } step_t;

endpackage

`default_nettype wire

[rtl/fixed_block_free_list_allocator_core.sv]
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core
// Pool allocator of equal-size entries opened in chunks, with a LIFO free
// list threaded through a next-link RAM and lazily linked fresh entries.
// ----------------------------------------------------------------------------
// Result: a request is held in the input register; its result is registered
//   in the execute state, which waits while an earlier result still waits
//   on the result stream. A new request is accepted only after the last one
//   has executed; the link RAM read at the list head is registered on accept.
// Reset: rst_ni clears the list head, chunk count, fresh mark and handshake
//   state at once; the link RAM is not cleared and needs no clearing pass.
`default_nettype none

module fixed_block_free_list_allocator_core
  import fbfl_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // request stream
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // entry_index[9:0], entry_is_null[10],
                                                       // size_matches[11], zero [15:12]
  input  wire logic [CMD_W-1:0]      s_axis_tuser_i,  // command[1:0]
  // result stream
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic      [OUT_DATA_W-1:0] m_axis_tdata_o,  // granted_index[9:0], zero [15:10]
  output logic      [STATUS_W-1:0]   m_axis_tuser_o   // status[2:0]
);

  fsm_e              state_q, state_d;
  item_t             item_q;
  pool_t             pool_q;
  step_t             step;
  logic [LINK_W-1:0] head_link;
  logic              in_accept;
  logic              exec_go;
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  out_granted_q;
  status_e           out_status_q;

  // handshake and sequencing
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    exec_go         = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        exec_go = !out_valid_q || m_axis_tready_i;
        if (exec_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.cmd           <= s_axis_tuser_i;
      item_q.entry_index   <= s_axis_tdata_i[IDX_W-1:0];
      item_q.entry_is_null <= s_axis_tdata_i[IDX_W];
      item_q.size_matches  <= s_axis_tdata_i[IDX_W+1];
    end
  end

  // link store, read at the head on accept
  fbfl_link_ram u_link_ram (
    .clk_i     (clk_i),
    .wr_en_i   (exec_go && step.wr_en),
    .wr_addr_i (step.wr_addr),
    .wr_data_i (step.wr_data),
    .rd_en_i   (in_accept),
    .rd_addr_i (pool_q.list_head[IDX_W-1:0]),
    .rd_data_o (head_link)
  );

  fbfl_step_logic u_step_logic (
    .item_i      (item_q),
    .pool_i      (pool_q),
    .head_link_i (head_link),
    .step_o      (step)
  );

  // pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q.list_head   <= NULL_LINK;
      pool_q.chunks_open <= '0;
      pool_q.fresh_mark  <= '0;
    end else if (exec_go) begin
      pool_q <= step.pool_next;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_go) begin
      out_valid_d = step.emit;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go && step.emit) begin
      out_granted_q <= step.granted;
      out_status_q  <= step.status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(out_granted_q);
  assign m_axis_tuser_o  = out_status_q;

`ifndef SYNTH
  // the head is an entry or null, never beyond
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pool_q.list_head > NULL_LINK))
    else $error("list head beyond null");

  // no more chunks than fit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_q.chunks_open <= USABLE_CHUNKS_L)
    else $error("too many chunks open");

  // fresh mark stays inside the opened region
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_q.fresh_mark <= LINK_W'(pool_q.chunks_open) * BLOCK_SIZE_L)
    else $error("fresh mark beyond opened chunks");

  // an accepted request puts the core in the execute state in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_EXEC))
    else $error("accepted request not executed");

  // only a grant carries an index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != ST_ALLOCATED)) |-> (out_granted_q == '0))
    else $error("index on a non-grant result");
`endif

endmodule

`default_nettype wire

[rtl/fbfl_link_ram.sv]
// ----------------------------------------------------------------------------
// fbfl_link_ram
// Next-link store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_link_ram
  import fbfl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [IDX_W-1:0]  wr_addr_i,
  input  wire logic [LINK_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [IDX_W-1:0]  rd_addr_i,
  output logic      [LINK_W-1:0] rd_data_o
);

  logic [LINK_W-1:0] mem_q [STORE_DEPTH];
  logic [LINK_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[rtl/fbfl_step_logic.sv]
// ----------------------------------------------------------------------------
// fbfl_step_logic
// Decides one request: pop, chunk open, push, pool reset or flag, from the pool state
// and the link already read at the list head.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_step_logic
  import fbfl_pkg::*;
(
  input  wire item_t             item_i,
  input  wire pool_t             pool_i,
  input  wire logic [LINK_W-1:0] head_link_i,
  output step_t                  step_o
);

  logic [LINK_W-1:0]  fresh_end;
  logic [LINK_W-1:0]  open_end;
  logic [LINK_W-1:0]  open_base;
  logic [LINK_W-1:0]  mark_up;
  logic [CHUNK_W-1:0] chunks_up;
  logic               head_valid;
  logic               head_fresh;

  // chunk bounds
  assign fresh_end  = LINK_W'(pool_i.chunks_open) * BLOCK_SIZE_L;
  assign chunks_up  = pool_i.chunks_open + CHUNK_W'(1);
  assign open_base  = fresh_end;
  assign open_end   = LINK_W'(chunks_up) * BLOCK_SIZE_L;
  assign head_valid = !pool_i.list_head[LINK_W-1];
  assign head_fresh = (pool_i.list_head == pool_i.fresh_mark) &&
                      (pool_i.fresh_mark < fresh_end);
  assign mark_up    = head_fresh ? pool_i.list_head + LINK_W'(1)
                                 : open_base + LINK_W'(1);

  // request decision
  always_comb begin
    step_o           = '0;
    step_o.pool_next = pool_i;
    step_o.status    = ST_ALLOCATED;
    step_o.wr_addr   = item_i.entry_index;
    step_o.wr_data   = pool_i.list_head;
    case (item_i.cmd)
      CMD_RESET: begin
        step_o.emit                  = 1'b1;
        step_o.status                = ST_POOL_RESET;
        step_o.pool_next.list_head   = NULL_LINK;
        step_o.pool_next.chunks_open = '0;
        step_o.pool_next.fresh_mark  = '0;
      end
      CMD_FREE: begin
        step_o.emit = 1'b1;
        if (item_i.entry_is_null) begin
          step_o.status = ST_NULL_IGN;
        end else if (!item_i.size_matches) begin
          step_o.status = ST_WRONG_SIZE;
        end else begin
          step_o.status              = ST_FREED;
          step_o.wr_en               = 1'b1;
          step_o.pool_next.list_head = {1'b0, item_i.entry_index};
        end
      end
      CMD_ALLOC: begin
        step_o.emit = 1'b1;
        if (!item_i.size_matches) begin
          step_o.status = ST_WRONG_SIZE;
        end else if (head_valid) begin
          // pop the head, implied link inside the fresh region
          step_o.granted = pool_i.list_head[IDX_W-1:0];
          if (head_fresh) begin
            step_o.pool_next.fresh_mark = mark_up;
            step_o.pool_next.list_head  = (mark_up < fresh_end) ? mark_up : NULL_LINK;
          end else if (head_link_i[LINK_W-1]) begin
            step_o.pool_next.list_head = NULL_LINK;
          end else begin
            step_o.pool_next.list_head = head_link_i;
          end
        end else if (pool_i.chunks_open >= USABLE_CHUNKS_L) begin
          step_o.status = ST_EXHAUSTED;
        end else begin
          // open the next chunk and hand out its first entry
          step_o.granted               = open_base[IDX_W-1:0];
          step_o.pool_next.chunks_open = chunks_up;
          step_o.pool_next.fresh_mark  = mark_up;
          step_o.pool_next.list_head   = (mark_up < open_end) ? mark_up : NULL_LINK;
        end
      end
      default: begin
        step_o.emit = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire
